### design/lpmt_pkg.sv
// Shared types and constants for the long-press mode toggle.
`timescale 1ns / 1ps

package lpmt_pkg;

   localparam int TIME_WIDTH   = 32;
   localparam int FIELD_WIDTH  = 32;
   localparam int CSR_IDX_WIDTH = 1;
   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 40;

   localparam logic [FIELD_WIDTH-1:0] HOLD_RESET_MS = 32'd2000;

   // hold register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ENTER_PROG = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LEAVE_PROG = 1'd1;

   typedef enum logic [1:0] {
      MODE_NORMAL    = 2'd0,
      MODE_TO_PROG   = 2'd1,
      MODE_PROG      = 2'd2,
      MODE_TO_NORMAL = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [TIME_WIDTH-1:0]   start;
      logic                    last_pressed;
   } state_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] enter_prog;
      logic [FIELD_WIDTH-1:0] leave_prog;
   } hold_type;

endpackage

### design/long_press_mode_toggle.sv
// Top level of the long-press mode toggle: word registers, state and config.
`timescale 1ns / 1ps

// Channel  | dir | tdata fields (low bit up)                 | tuser/tlast
// ---------+-----+-------------------------------------------+------------
// req_     | in  | time_now_ms[31:0], button_level[32], pad  | none
// rsp_     | out | mode[1:0], elapsed_ms[33:2], pad          | none
// csr_     | in  | we, index (0 enter hold, 1 leave hold)    | -
//
// Each word passes through the input register and then the result register;
// a new word is accepted every cycle while the rsp side is not stalled, so
// throughput is one word per cycle. rsp valid rises once the word has moved
// on from the input register into the result register.
// The single step (a subtract, compares, mode update) sits between the
// input register and the result register.
// Reset: synchronous, active high; mode normal, start time zero, not pressed,
// both hold times 2000 ms. A stalled rsp side holds the result register, and a full input register, in place.

module long_press_mode_toggle (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // time_now_ms[31:0], button_level[32], zero pad [39:33]
   input  logic [lpmt_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // mode[1:0], elapsed_ms[33:2], zero pad [39:34]
   output logic [lpmt_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   input  logic                                    csr_we,
   input  logic [lpmt_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [lpmt_pkg::FIELD_WIDTH-1:0]        csr_wdata
);
   import lpmt_pkg::*;

   // input register
   logic                   in_valid_ff;
   logic [FIELD_WIDTH-1:0] in_time_ff;
   logic                   in_level_ff;

   // result register
   logic                   out_valid_ff;
   mode_type               out_mode_ff;
   logic [FIELD_WIDTH-1:0] out_elapsed_ff;

   // block state and hold times
   state_type              state_ff;
   state_type              state_in;
   hold_type               hold_ff;
   hold_type               hold_in;

   logic [FIELD_WIDTH-1:0] elapsed;
   logic                   out_open;
   logic                   advance;

   // result register frees when empty or being taken this cycle
   assign out_open   = ~out_valid_ff | rsp_tready;
   // move the held word through the step into the result register
   assign advance    = in_valid_ff & out_open;
   assign req_tready = ~in_valid_ff | out_open;

   lpmt_step u_step (
      .state        (state_ff),
      .hold         (hold_ff),
      .time_now_ms  (in_time_ff),
      .button_level (in_level_ff),
      .state_next   (state_in),
      .elapsed_ms   (elapsed)
   );

   // capture incoming words
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_time_ff  <= req_tdata[FIELD_WIDTH-1:0];
         in_level_ff <= req_tdata[FIELD_WIDTH];
      end
   end

   // load result and commit state on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_NORMAL, start: '0, last_pressed: 1'b0};
      end else begin
         if (out_open) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_mode_ff    <= state_in.mode;
         out_elapsed_ff <= elapsed;
      end
   end

   // configuration writes
   always_comb begin
      hold_in = hold_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENTER_PROG: hold_in.enter_prog = csr_wdata;
            CSR_LEAVE_PROG: hold_in.leave_prog = csr_wdata;
            default:        hold_in = hold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '{enter_prog: HOLD_RESET_MS, leave_prog: HOLD_RESET_MS};
      end else begin
         hold_ff <= hold_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_WIDTH - FIELD_WIDTH - 2)'(0), out_elapsed_ff, out_mode_ff};

   // reported mode matches the committed state after each advance
   a_mode_matches: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_mode_ff == state_ff.mode))
      else $error("reported mode differs from committed state");

   // state holds between words
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a word");

   // a timestamp behind the start only moves the start
   a_behind_resync: assert property (@(posedge clock) disable iff (reset)
      (advance && (TIME_WIDTH'(in_time_ff) < state_ff.start)) |=>
      (state_ff.start == TIME_WIDTH'($past(in_time_ff)) &&
       state_ff.mode == $past(state_ff.mode) &&
       state_ff.last_pressed == $past(state_ff.last_pressed) &&
       out_elapsed_ff == '0))
      else $error("behind-start word changed more than the start time");

   // entering the hold phase from normal mode restarts elapsed time
   a_hold_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.mode == MODE_NORMAL && state_in.mode == MODE_TO_PROG) |=>
      (out_elapsed_ff == '0))
      else $error("hold entry did not restart elapsed time");

endmodule

### design/lpmt_step.sv
// One update step of the mode state from a single timestamp and button level.
`timescale 1ns / 1ps

module lpmt_step (
   input  lpmt_pkg::state_type                    state,
   input  lpmt_pkg::hold_type                     hold,
   input  logic [lpmt_pkg::FIELD_WIDTH-1:0]       time_now_ms,
   input  logic                                   button_level,
   output lpmt_pkg::state_type                    state_next,
   output logic [lpmt_pkg::FIELD_WIDTH-1:0]       elapsed_ms
);
   import lpmt_pkg::*;

   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] held;
   logic                  pressed;
   logic                  press_edge;
   logic                  behind;
   logic                  restart;

   assign now        = TIME_WIDTH'(time_now_ms);
   assign pressed    = ~button_level;
   assign press_edge = pressed & ~state.last_pressed;
   assign behind     = now < state.start;
   assign held       = now - state.start;

   always_comb begin
      state_next = state;
      restart    = 1'b0;
      if (behind) begin
         // resync start time only
         state_next.start = now;
         restart          = 1'b1;
      end else begin
         state_next.last_pressed = pressed;
         case (state.mode)
            MODE_NORMAL: begin
               if (press_edge) begin
                  state_next.mode  = MODE_TO_PROG;
                  state_next.start = now;
                  restart          = 1'b1;
               end
            end
            MODE_TO_PROG: begin
               if (!pressed) begin
                  state_next.mode = MODE_NORMAL;
               end else if (64'(held) >= 64'(hold.enter_prog)) begin
                  state_next.mode = MODE_PROG;
               end
            end
            MODE_PROG: begin
               if (press_edge) begin
                  state_next.mode  = MODE_TO_NORMAL;
                  state_next.start = now;
                  restart          = 1'b1;
               end
            end
            MODE_TO_NORMAL: begin
               if (!pressed) begin
                  state_next.mode = MODE_PROG;
               end else if (64'(held) >= 64'(hold.leave_prog)) begin
                  state_next.mode = MODE_NORMAL;
               end
            end
            default: begin
               state_next = state;
            end
         endcase
      end
   end

   // start moved to now means zero elapsed
   assign elapsed_ms = restart ? '0 : FIELD_WIDTH'(held);

endmodule
